[design/ohlcba_pkg.sv]
// shared types, codes and constant tables for the ohlc bar aggregator
// no dependencies; imported by every module of the block
package ohlcba_pkg;

    localparam int PRICE_W  = 30;
    localparam int MINUTE_W = 6;
    localparam int WLEN_W   = 8;
    localparam int SUM_W    = PRICE_W + WLEN_W;
    localparam int BM_W     = 5;
    localparam int NMIN     = 1 << MINUTE_W;

    localparam logic [PRICE_W-1:0] MIN_START = 30'd1000000000;

    // command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_AVG  = 2'd1;
    localparam logic [1:0] CMD_MAX  = 2'd2;
    localparam logic [1:0] CMD_MIN  = 2'd3;

    // field select codes
    localparam logic [1:0] FLD_CLOSE = 2'd0;
    localparam logic [1:0] FLD_HIGH  = 2'd1;
    localparam logic [1:0] FLD_LOW   = 2'd2;
    localparam logic [1:0] FLD_OPEN  = 2'd3;

    // accepted bar lengths in minutes
    localparam logic [BM_W-1:0] BM_1  = 5'd1;
    localparam logic [BM_W-1:0] BM_2  = 5'd2;
    localparam logic [BM_W-1:0] BM_3  = 5'd3;
    localparam logic [BM_W-1:0] BM_5  = 5'd5;
    localparam logic [BM_W-1:0] BM_6  = 5'd6;
    localparam logic [BM_W-1:0] BM_10 = 5'd10;
    localparam logic [BM_W-1:0] BM_15 = 5'd15;
    localparam logic [BM_W-1:0] BM_30 = 5'd30;

    typedef struct packed {
        logic [PRICE_W-1:0] open_p;
        logic [PRICE_W-1:0] high_p;
        logic [PRICE_W-1:0] low_p;
        logic [PRICE_W-1:0] close_p;
    } bar_t;

    // one bit per minute code, set where the minute is a multiple of b
    function automatic logic [NMIN-1:0] boundary_mask(input int unsigned b);
        logic [NMIN-1:0] m;
        int unsigned     c;
        m = '0;
        c = 0;
        for (int i = 0; i < NMIN; i++)
        begin
            m[i] = (c == 0);
            c = c + 1;
            if (c == b)
            begin
                c = 0;
            end
        end
        return m;
    endfunction

    localparam logic [NMIN-1:0] BND_1  = boundary_mask(1);
    localparam logic [NMIN-1:0] BND_2  = boundary_mask(2);
    localparam logic [NMIN-1:0] BND_3  = boundary_mask(3);
    localparam logic [NMIN-1:0] BND_5  = boundary_mask(5);
    localparam logic [NMIN-1:0] BND_6  = boundary_mask(6);
    localparam logic [NMIN-1:0] BND_10 = boundary_mask(10);
    localparam logic [NMIN-1:0] BND_15 = boundary_mask(15);
    localparam logic [NMIN-1:0] BND_30 = boundary_mask(30);

    // pick one field of a stored bar
    function automatic logic [PRICE_W-1:0] select_field(input bar_t b, input logic [1:0] sel);
        logic [PRICE_W-1:0] v;
        unique case (sel)
            FLD_CLOSE: v = b.close_p;
            FLD_HIGH:  v = b.high_p;
            FLD_LOW:   v = b.low_p;
            FLD_OPEN:  v = b.open_p;
            default:   v = b.open_p;
        endcase
        return v;
    endfunction

endpackage

[design/ohlcba_bar_mem.sv]
// bar ring storage: one write port, one read port with registered data
// depends on ohlcba_pkg for the bar_t record
module ohlcba_bar_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  ohlcba_pkg::bar_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output ohlcba_pkg::bar_t rdata
);
    import ohlcba_pkg::*;

    bar_t mem [DEPTH];
    bar_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/ohlcba_div.sv]
// restoring divider for the window average, one quotient bit per cycle
// depends on ohlcba_pkg for the sum and window widths
module ohlcba_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ohlcba_pkg::SUM_W-1:0] dividend,
    input  logic [ohlcba_pkg::WLEN_W-1:0] divisor,
    output logic                         done,
    output logic [ohlcba_pkg::SUM_W-1:0] quotient
);
    import ohlcba_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [WLEN_W-1:0] rem_reg, rem_next;
    logic [WLEN_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WLEN_W:0]   trial;
    logic [WLEN_W:0]   diff;
    logic              fits;

    // one shift and trial subtract per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? diff[WLEN_W-1:0] : trial[WLEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/ohlc_bar_aggregator_with_window_stats.sv]
// top level of the ohlc bar aggregator: sequencer, bar state and window walk
// depends on ohlcba_pkg, ohlcba_bar_mem and ohlcba_div
//
// usage:
//   a beat is taken on a rising edge with start high and busy low. cmd picks a
//   price tick or a window query (average, maximum, minimum of close, high,
//   low or open over window_len bars after skipping bars_back newest bars).
//   every beat gives exactly one result: done is high for one cycle with value
//   and new_bar on their ports. the receiver cannot stall; the result is taken
//   in that cycle. a new beat may be taken in the same cycle the result shows.
// sequence:
//   a tick that opens a bar writes the bar ring once; a tick that updates a bar
//   does one read and one write of the bar ring. a query with window_len 0 is
//   answered from idle. a max/min query goes through setup and then walks n bars
//   (at most MAX_BARS), one ring read per cycle, and then folds the last read;
//   an average query then runs the bit-serial divider on the sum.
//   a new beat is not taken until the last result shows; busy is high in between.
// config: bar_minutes_we writes bar_minutes_wdata at once if it is 1, 2, 3, 5,
//   6, 10, 15 or 30; other values are dropped. write only while idle.
// reset: asynchronous, clears bar count, newest slot and sets bar length 1.
//   ring contents are left as they are; only held bars are ever read.
module ohlc_bar_aggregator_with_window_stats #(
    parameter int MAX_BARS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       cmd,
    input  logic [1:0]                       field_sel,
    input  logic [ohlcba_pkg::MINUTE_W-1:0]  tick_minute,
    input  logic [ohlcba_pkg::PRICE_W-1:0]   price,
    input  logic [ohlcba_pkg::WLEN_W-1:0]    window_len,
    input  logic [ohlcba_pkg::WLEN_W-1:0]    bars_back,
    input  logic                             bar_minutes_we,
    input  logic [ohlcba_pkg::BM_W-1:0]      bar_minutes_wdata,
    output logic                             done,
    output logic [ohlcba_pkg::PRICE_W-1:0]   value,
    output logic                             new_bar
);
    import ohlcba_pkg::*;

    localparam int AW = $clog2(MAX_BARS);
    localparam int HW = $clog2(MAX_BARS + 1);
    localparam int KW = (HW > WLEN_W + 1) ? HW : WLEN_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_TICK_UPD,
        S_Q_SETUP,
        S_Q_WALK,
        S_Q_DIV
    } state_t;

    state_t state_reg, state_next;

    // latched beat
    logic [1:0]          cmd_reg, cmd_next;
    logic [1:0]          sel_reg, sel_next;
    logic [MINUTE_W-1:0] minute_reg, minute_next;
    logic [PRICE_W-1:0]  price_reg, price_next;
    logic [WLEN_W-1:0]   wlen_reg, wlen_next;
    logic [WLEN_W-1:0]   back_reg, back_next;

    // bar bookkeeping
    logic [BM_W-1:0]     bar_minutes_reg, bar_minutes_next;
    logic [MINUTE_W-1:0] start_min_reg, start_min_next;
    logic                have_bar_reg, have_bar_next;
    logic [AW-1:0]       newest_reg, newest_next;
    logic [HW-1:0]       held_reg, held_next;

    // window walk
    logic [KW-1:0]       k_reg, k_next;
    logic [KW-1:0]       end_reg, end_next;
    logic [AW-1:0]       slot_reg, slot_next;
    logic                pend_reg, pend_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [PRICE_W-1:0]  max_reg, max_next;
    logic [PRICE_W-1:0]  min_reg, min_next;

    // result
    logic                done_reg, done_next;
    logic [PRICE_W-1:0]  value_reg, value_next;
    logic                new_bar_reg, new_bar_next;

    // ring and divider hookup
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    bar_t                mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    bar_t                mem_rdata;
    logic                div_start;
    logic                div_done;
    logic [SUM_W-1:0]    div_quo;

    // helpers
    logic [NMIN-1:0]     bnd_mask;
    logic                open_new;
    logic [AW-1:0]       slot_inc;
    logic [AW-1:0]       back_slot;
    logic [KW-1:0]       win_end;
    logic [KW-1:0]       held_k;
    logic [PRICE_W-1:0]  fv;

    ohlcba_bar_mem #(
        .DEPTH (MAX_BARS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ohlcba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (wlen_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // minute boundary table for the current bar length
    always_comb
    begin
        unique case (bar_minutes_reg)
            BM_1:    bnd_mask = BND_1;
            BM_2:    bnd_mask = BND_2;
            BM_3:    bnd_mask = BND_3;
            BM_5:    bnd_mask = BND_5;
            BM_6:    bnd_mask = BND_6;
            BM_10:   bnd_mask = BND_10;
            BM_15:   bnd_mask = BND_15;
            BM_30:   bnd_mask = BND_30;
            default: bnd_mask = BND_1;
        endcase
    end

    assign open_new = !have_bar_reg ||
                      ((minute_reg != start_min_reg) && bnd_mask[minute_reg]);
    assign slot_inc = (newest_reg == AW'(MAX_BARS - 1)) ? '0 : newest_reg + 1'b1;
    assign back_slot = AW'(back_reg);
    assign held_k    = KW'(held_reg);
    assign win_end   = KW'({1'b0, back_reg} + {1'b0, wlen_reg});
    assign fv        = select_field(mem_rdata, sel_reg);

    // sequencer and datapath next state
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        sel_next         = sel_reg;
        minute_next      = minute_reg;
        price_next       = price_reg;
        wlen_next        = wlen_reg;
        back_next        = back_reg;
        bar_minutes_next = bar_minutes_reg;
        start_min_next   = start_min_reg;
        have_bar_next    = have_bar_reg;
        newest_next      = newest_reg;
        held_next        = held_reg;
        k_next           = k_reg;
        end_next         = end_reg;
        slot_next        = slot_reg;
        pend_next        = 1'b0;
        sum_next         = sum_reg;
        max_next         = max_reg;
        min_next         = min_reg;
        done_next        = 1'b0;
        value_next       = value_reg;
        new_bar_next     = new_bar_reg;
        mem_we           = 1'b0;
        mem_waddr        = newest_reg;
        mem_wdata        = '{open_p: price_reg, high_p: price_reg,
                             low_p: price_reg, close_p: price_reg};
        mem_re           = 1'b0;
        mem_raddr        = newest_reg;
        div_start        = 1'b0;

        // configuration write
        if (bar_minutes_we)
        begin
            unique case (bar_minutes_wdata)
                BM_1, BM_2, BM_3, BM_5, BM_6, BM_10, BM_15, BM_30:
                    bar_minutes_next = bar_minutes_wdata;
                default:
                    bar_minutes_next = bar_minutes_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    sel_next    = field_sel;
                    minute_next = tick_minute;
                    price_next  = price;
                    wlen_next   = window_len;
                    back_next   = bars_back;
                    if (cmd == CMD_TICK)
                    begin
                        state_next = S_TICK;
                    end
                    else if (window_len == '0)
                    begin
                        done_next    = 1'b1;
                        value_next   = '0;
                        new_bar_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_Q_SETUP;
                    end
                end
            end

            S_TICK:
            begin
                if (open_new)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = have_bar_reg ? slot_inc : '0;
                    newest_next    = have_bar_reg ? slot_inc : '0;
                    have_bar_next  = 1'b1;
                    start_min_next = minute_reg;
                    if (held_reg < HW'(MAX_BARS))
                    begin
                        held_next = held_reg + 1'b1;
                    end
                    done_next    = 1'b1;
                    value_next   = '0;
                    new_bar_next = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_TICK_UPD;
                end
            end

            S_TICK_UPD:
            begin
                mem_we            = 1'b1;
                mem_wdata         = mem_rdata;
                mem_wdata.close_p = price_reg;
                if (price_reg > mem_rdata.high_p)
                begin
                    mem_wdata.high_p = price_reg;
                end
                if (price_reg < mem_rdata.low_p)
                begin
                    mem_wdata.low_p = price_reg;
                end
                done_next    = 1'b1;
                value_next   = '0;
                new_bar_next = 1'b0;
                state_next   = S_IDLE;
            end

            S_Q_SETUP:
            begin
                sum_next   = '0;
                max_next   = '0;
                min_next   = MIN_START;
                k_next     = KW'(back_reg);
                end_next   = (win_end < held_k) ? win_end : held_k;
                slot_next  = (newest_reg >= back_slot) ? newest_reg - back_slot
                           : newest_reg + AW'(MAX_BARS) - back_slot;
                state_next = S_Q_WALK;
            end

            S_Q_WALK:
            begin
                if (k_reg < end_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = slot_reg;
                    pend_next = 1'b1;
                    k_next    = k_reg + 1'b1;
                    slot_next = (slot_reg == '0) ? AW'(MAX_BARS - 1) : slot_reg - 1'b1;
                end
                else if (!pend_reg)
                begin
                    if (cmd_reg == CMD_AVG)
                    begin
                        div_start  = 1'b1;
                        state_next = S_Q_DIV;
                    end
                    else
                    begin
                        done_next    = 1'b1;
                        value_next   = (cmd_reg == CMD_MAX) ? max_reg : min_reg;
                        new_bar_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                end
            end

            S_Q_DIV:
            begin
                if (div_done)
                begin
                    done_next    = 1'b1;
                    value_next   = div_quo[PRICE_W-1:0];
                    new_bar_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // fold in the bar read on the previous cycle
        if (pend_reg)
        begin
            sum_next = sum_reg + SUM_W'(fv);
            if (fv > max_reg)
            begin
                max_next = fv;
            end
            if (fv < min_reg)
            begin
                min_next = fv;
            end
        end
    end

    // control state, bar bookkeeping and the registered done output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            bar_minutes_reg <= BM_1;
            start_min_reg   <= '0;
            have_bar_reg    <= 1'b0;
            newest_reg      <= '0;
            held_reg        <= '0;
            pend_reg        <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            bar_minutes_reg <= bar_minutes_next;
            start_min_reg   <= start_min_next;
            have_bar_reg    <= have_bar_next;
            newest_reg      <= newest_next;
            held_reg        <= held_next;
            pend_reg        <= pend_next;
            done_reg        <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        sel_reg     <= sel_next;
        minute_reg  <= minute_next;
        price_reg   <= price_next;
        wlen_reg    <= wlen_next;
        back_reg    <= back_next;
        k_reg       <= k_next;
        end_reg     <= end_next;
        slot_reg    <= slot_next;
        sum_reg     <= sum_next;
        max_reg     <= max_next;
        min_reg     <= min_next;
        value_reg   <= value_next;
        new_bar_reg <= new_bar_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign value   = value_reg;
    assign new_bar = new_bar_reg;

endmodule
